// ===== rtl/lzwvw_pkg.sv =====
`default_nettype none
package lzwvw_pkg;

   localparam int unsigned WIDTH_W     = 5;
   localparam int unsigned SEED_CODES  = 256;
   localparam int unsigned EPOCH_W     = 8;
   localparam int unsigned CODE_OUT_W  = 12;
   localparam int unsigned WIDTH_OUT_W = 4;
   localparam logic [WIDTH_W-1:0] START_WIDTH = 5'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_CMP,
      ST_OUT_MISS,
      ST_LOAD_FINAL,
      ST_OUT_FINAL,
      ST_CLEAR
   } lzw_state_type;

   typedef struct packed {
      logic load_in;
      logic start_msg;
      logic probe_start;
      logic probe_next;
      logic rd_en;
      logic hit;
      logic miss;
      logic emit_final;
      logic clr_step;
   } lzw_cmd_type;

   typedef struct packed {
      logic prefix_valid;
      logic in_last;
      logic slot_live;
      logic key_match;
      logic need_clear;
      logic clr_last;
   } lzw_status_type;

endpackage
`default_nettype wire

// ===== rtl/lzwvw_ctrl.sv =====
`default_nettype none
module lzwvw_ctrl
   import lzwvw_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   input  wire lzw_status_type status,
   output lzw_cmd_type         cmd
);

   lzw_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (status.need_clear) begin
               state_in = ST_CLEAR;
            end else begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load_in = 1'b1;
                  state_in    = ST_DECODE;
               end
            end
         end
         ST_DECODE: begin
            if (!status.prefix_valid) begin
               cmd.start_msg = 1'b1;
               state_in = status.in_last ? ST_LOAD_FINAL : ST_IDLE;
            end else begin
               cmd.probe_start = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            if (status.slot_live && status.key_match) begin
               cmd.hit  = 1'b1;
               state_in = status.in_last ? ST_LOAD_FINAL : ST_IDLE;
            end else if (status.slot_live) begin
               // occupied by another key, try the next slot
               cmd.probe_next = 1'b1;
               state_in = ST_READ;
            end else begin
               cmd.miss = 1'b1;
               state_in = ST_OUT_MISS;
            end
         end
         ST_OUT_MISS: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = status.in_last ? ST_LOAD_FINAL : ST_IDLE;
            end
         end
         ST_LOAD_FINAL: begin
            cmd.emit_final = 1'b1;
            state_in = ST_OUT_FINAL;
         end
         ST_OUT_FINAL: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE) && !status.need_clear)
      else $error("input taken while busy");

   a_rsp_only_after_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(cmd.miss) || $past(cmd.emit_final)))
      else $error("result shown without a load");

   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !rsp_tvalid && !req_tready)
      else $error("clearing overlaps traffic");

endmodule
`default_nettype wire

// ===== rtl/lzwvw_dp.sv =====
`default_nettype none
module lzwvw_dp
   import lzwvw_pkg::*;
#(
   parameter int unsigned DICT_SIZE = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             in_byte,
   input  wire logic                   in_last,
   input  wire lzw_cmd_type            cmd,
   output lzw_status_type              status,
   output logic [CODE_OUT_W-1:0]       code_value,
   output logic [WIDTH_OUT_W-1:0]      code_width,
   output logic                        end_of_message
);

   localparam int unsigned CW    = $clog2(DICT_SIZE);
   localparam int unsigned AW    = CW + 1;
   localparam int unsigned KW    = CW + 8;
   localparam int unsigned EW    = EPOCH_W;
   localparam int unsigned ENT_W = EW + CW + KW;
   localparam int unsigned TSIZE = 2 ** AW;

   logic [ENT_W-1:0] table_mem [TSIZE];

   logic [7:0]          byte_ff;
   logic                last_ff;
   logic [CW-1:0]       prefix_ff;
   logic                prefix_valid_ff;
   logic [CW:0]         count_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic [EW-1:0]       epoch_ff;
   logic                need_clear_ff;
   logic [AW-1:0]       clr_addr_ff;
   logic [AW-1:0]       addr_ff;
   logic [ENT_W-1:0]    rd_ff;
   logic [CW-1:0]       out_code_ff;
   logic [WIDTH_W-1:0]  out_width_ff;
   logic                out_eom_ff;

   logic [KW-1:0]       key;
   logic [AW-1:0]       hash;
   logic [EW-1:0]       rd_epoch;
   logic [CW-1:0]       rd_code;
   logic [KW-1:0]       rd_key;
   logic                dict_full;
   logic [CW:0]         count_next;
   logic [CW:0]         width_limit;
   logic [CW+CODE_OUT_W-1:0] code_ext;

   assign key         = {prefix_ff, byte_ff};
   assign hash        = AW'(prefix_ff) ^ (AW'(byte_ff) << (AW - 8));
   assign rd_epoch    = rd_ff[EW-1:0];
   assign rd_code     = rd_ff[EW+CW-1:EW];
   assign rd_key      = rd_ff[ENT_W-1:EW+CW];
   assign dict_full   = (count_ff >= (CW+1)'(DICT_SIZE));
   assign count_next  = count_ff + 1'b1;
   assign width_limit = (CW+1)'(1) << width_ff;

   assign status.prefix_valid = prefix_valid_ff;
   assign status.in_last      = last_ff;
   assign status.slot_live    = (rd_epoch == epoch_ff);
   assign status.key_match    = (rd_key == key);
   assign status.need_clear   = need_clear_ff;
   assign status.clr_last     = (clr_addr_ff == {AW{1'b1}});

   assign code_ext       = (CW+CODE_OUT_W)'(out_code_ff);
   assign code_value     = code_ext[CODE_OUT_W-1:0];
   assign code_width     = out_width_ff[WIDTH_OUT_W-1:0];
   assign end_of_message = out_eom_ff;

   // table: write port and registered read port
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         table_mem[clr_addr_ff] <= '0;
      end else if (cmd.miss && !dict_full) begin
         table_mem[addr_ff] <= {key, count_ff[CW-1:0], epoch_ff};
      end
      if (cmd.rd_en) begin
         rd_ff <= table_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         byte_ff <= in_byte;
         last_ff <= in_last;
      end
      if (cmd.probe_start) begin
         addr_ff <= hash;
      end else if (cmd.probe_next) begin
         addr_ff <= addr_ff + 1'b1;
      end
      if (cmd.miss) begin
         out_code_ff  <= prefix_ff;
         out_width_ff <= width_ff;
         out_eom_ff   <= 1'b0;
      end else if (cmd.emit_final) begin
         out_code_ff  <= prefix_ff;
         out_width_ff <= width_ff;
         out_eom_ff   <= 1'b1;
      end
      if (cmd.start_msg || cmd.miss) begin
         prefix_ff <= CW'(byte_ff);
      end else if (cmd.hit) begin
         prefix_ff <= rd_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_valid_ff <= 1'b0;
         count_ff        <= (CW+1)'(SEED_CODES);
         width_ff        <= START_WIDTH;
         epoch_ff        <= '0;
         need_clear_ff   <= 1'b1;
         clr_addr_ff     <= '0;
      end else begin
         if (cmd.start_msg) begin
            prefix_valid_ff <= 1'b1;
         end
         if (cmd.miss && !dict_full) begin
            count_ff <= count_next;
            if (count_next < (CW+1)'(DICT_SIZE) && count_next == width_limit) begin
               width_ff <= width_ff + 1'b1;
            end
         end
         if (cmd.emit_final) begin
            prefix_valid_ff <= 1'b0;
            count_ff        <= (CW+1)'(SEED_CODES);
            width_ff        <= START_WIDTH;
            // epoch zero marks an empty slot, so a wrap needs a sweep
            if (epoch_ff == {EW{1'b1}}) begin
               need_clear_ff <= 1'b1;
            end else begin
               epoch_ff <= epoch_ff + 1'b1;
            end
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (status.clr_last) begin
               need_clear_ff <= 1'b0;
               epoch_ff      <= EW'(1);
            end
         end
      end
   end

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.miss && !dict_full) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("entry count did not advance on insert");

   a_width_floor: assert property (@(posedge clock) disable iff (reset)
      width_ff >= START_WIDTH)
      else $error("code width below start width");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_final |=> !prefix_valid_ff && count_ff == (CW+1)'(SEED_CODES))
      else $error("dictionary not reset after final code");

endmodule
`default_nettype wire

// ===== rtl/lzw_variable_width_compressor_top.sv =====
`default_nettype none
// lzw compressor with variable code width
// req channel: one transaction per raw byte, req_tlast marks the final byte
// of a message. rsp channel: one transaction per emitted code, with the code
// in rsp_tdata[11:0], its width (9..12 by default) in rsp_tdata[15:12] and
// rsp_tlast on the final code of a message.
// the byte that starts a message is taken in idle and settled in decode. any
// other byte also passes a table read and a compare, and each further linear
// probe of the hash table repeats that read and compare; the table is a
// single-port-read memory of 2*DICT_SIZE slots and that read loop sets the rate.
// a dictionary miss adds an output state for its code, and the final code of
// a message a load state and an output state; an output state is left only when
// rsp_tready is high, and the next byte is held off until every code is taken.
// after reset, and after every 255th message, a clearing pass writes all
// 2*DICT_SIZE slots one per cycle while req_tready stays low. when the receiver
// stalls, the code waits in the output register and no further byte is taken.
module lzw_variable_width_compressor_top
   import lzwvw_pkg::*;
#(
   parameter int unsigned DICT_SIZE = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [11:0] code_value, [15:12] code_width
   output logic             rsp_tlast
);

   lzw_cmd_type    cmd;
   lzw_status_type status;
   logic [CODE_OUT_W-1:0]  code_value;
   logic [WIDTH_OUT_W-1:0] code_width;

   lzwvw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lzwvw_dp #(
      .DICT_SIZE (DICT_SIZE)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .in_byte        (req_tdata),
      .in_last        (req_tlast),
      .cmd            (cmd),
      .status         (status),
      .code_value     (code_value),
      .code_width     (code_width),
      .end_of_message (rsp_tlast)
   );

   assign rsp_tdata = {code_width, code_value};

endmodule
`default_nettype wire

// ===== tb/tb_lzw_variable_width_compressor_top.sv =====
module tb_lzw_variable_width_compressor_top;
   import lzwvw_pkg::*;

   localparam int unsigned DICT_SIZE  = 4096;
   localparam int          LIMIT_CYC  = 3000000;

   typedef struct {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       drain_first;   // wait for all codes before offering this byte
   } byte_item_type;

   typedef struct {
      logic [CODE_OUT_W-1:0]  code_value;
      logic [WIDTH_OUT_W-1:0] code_width;
      logic                   end_of_message;
   } code_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [11:0] code_value, [15:12] code_width
   logic        rsp_tlast;

   byte_item_type byte_q[$];
   code_item_type code_q[$];
   int         n_errors = 0;
   int         n_offered = 0;
   int         n_total = 0;

   // compressor state mirror
   int                     dict_map[int];
   int                     entry_count = SEED_CODES;
   int                     prefix_code = 0;
   bit                     prefix_valid = 0;
   logic [WIDTH_OUT_W-1:0] width_now = WIDTH_OUT_W'(START_WIDTH);

   lzw_variable_width_compressor_top #(.DICT_SIZE(DICT_SIZE)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      n_errors++;
   endtask

   task automatic push_code(input int code, input bit eom);
      code_item_type c;
      c.code_value     = CODE_OUT_W'(code);
      c.code_width     = width_now;
      c.end_of_message = eom;
      code_q.push_back(c);
   endtask

   task automatic compress_byte(input logic [7:0] b, input logic last);
      int key;
      if (!prefix_valid) begin
         prefix_code  = b;
         prefix_valid = 1;
      end else begin
         key = (prefix_code << 8) | b;
         if (dict_map.exists(key)) begin
            prefix_code = dict_map[key];
         end else begin
            push_code(prefix_code, 1'b0);
            if (entry_count < DICT_SIZE) begin
               dict_map[key] = entry_count;
               entry_count++;
               if (entry_count < DICT_SIZE && entry_count >= (1 << width_now))
                  width_now++;
            end
            prefix_code = b;
         end
      end
      if (last) begin
         push_code(prefix_code, 1'b1);
         dict_map.delete();
         entry_count  = SEED_CODES;
         prefix_code  = 0;
         prefix_valid = 0;
         width_now    = WIDTH_OUT_W'(START_WIDTH);
      end
   endtask

   task automatic add_message(input int len, input int top);
      byte_item_type it;
      for (int i = 0; i < len; i++) begin
         it.data_byte   = 8'($urandom_range(top));
         it.last_byte   = (i == len - 1);
         it.drain_first = 0;
         byte_q.push_back(it);
      end
   endtask

   task automatic add_bytes(input logic [7:0] vals[$]);
      byte_item_type it;
      foreach (vals[i]) begin
         it.data_byte   = vals[i];
         it.last_byte   = (i == vals.size() - 1);
         it.drain_first = 0;
         byte_q.push_back(it);
      end
   endtask

   function automatic int phase_of(input int idx);
      if (idx < n_total / 3) return 0;
      if (idx < 2 * n_total / 3) return 1;
      return 2;
   endfunction

   // driver
   always @(posedge clock) begin
      int pct;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         pct = (phase_of(n_offered) == 0) ? 13 : (phase_of(n_offered) == 1) ? 57 : 0;
         if (byte_q.size() > 0
             && !(byte_q[0].drain_first && (code_q.size() != 0 || req_tvalid))
             && $urandom_range(99) >= pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= byte_q[0].data_byte;
            req_tlast  <= byte_q[0].last_byte;
            void'(byte_q.pop_front());
            n_offered++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      int pct;
      pct = (phase_of(n_offered) == 0) ? 57 : (phase_of(n_offered) == 1) ? 13 : 0;
      rsp_tready <= ($urandom_range(99) >= pct);
   end

   // monitor
   always @(posedge clock) begin
      code_item_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (code_q.size() == 0) begin
               report_mismatch("unexpected code", rsp_tdata[11:0], -1);
            end else begin
               want = code_q.pop_front();
               if (rsp_tdata[11:0] !== want.code_value)
                  report_mismatch("code_value", rsp_tdata[11:0], want.code_value);
               if (rsp_tdata[15:12] !== want.code_width)
                  report_mismatch("code_width", rsp_tdata[15:12], want.code_width);
               if (rsp_tlast !== want.end_of_message)
                  report_mismatch("end_of_message", rsp_tlast, want.end_of_message);
            end
         end
         if (req_tvalid && req_tready)
            compress_byte(req_tdata, req_tlast);
      end
   end

   initial begin
      // single-byte messages at both extremes
      add_bytes('{8'h00});
      add_bytes('{8'hff});
      // repeated bytes hit the dictionary
      add_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      add_bytes('{8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff});
      add_bytes('{8'h55, 8'haa, 8'h80, 8'h01});
      // long message grows the width past 10 bits
      add_message(1100, 255);
      // enough short messages to wrap the table epoch
      for (int m = 0; m < 280; m++) begin
         add_message($urandom_range(4, 1), ($urandom_range(2) == 0) ? 3 : 255);
      end
      n_total = byte_q.size();
      byte_q[n_total / 2].drain_first = 1;
      byte_q[n_total - n_total / 3].drain_first = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (byte_q.size() != 0 || req_tvalid) @(posedge clock);
      while (code_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (n_errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      repeat (LIMIT_CYC) @(posedge clock);
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lzwvw_pkg.sv
rtl/lzwvw_ctrl.sv
rtl/lzwvw_dp.sv
rtl/lzw_variable_width_compressor_top.sv
tb/tb_lzw_variable_width_compressor_top.sv
